>>> hdl/eight_bit_alu_with_flags_defines.svh
// Assertion macros for the eight-bit ALU with flags.
// Used by the top level; needs a signal named clk and an active-low rst_n in scope.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
`define EBALU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");
`define EBALU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");
`else
`define EBALU_ASSERT_IMP(lbl, pre, post)
`define EBALU_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> hdl/ebalu_pkg.sv
// Shared types for the eight-bit ALU with flags: operation codes, item and result structs.
// No dependencies.
package ebalu_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_RLC  = 5'd8,
    OP_RRC  = 5'd9,
    OP_RL   = 5'd10,
    OP_RR   = 5'd11,
    OP_SLA  = 5'd12,
    OP_SRA  = 5'd13,
    OP_SWAP = 5'd14,
    OP_SRL  = 5'd15,
    OP_BIT  = 5'd16,
    OP_RES  = 5'd17,
    OP_SET  = 5'd18,
    OP_DAA  = 5'd19,
    OP_CPL  = 5'd20,
    OP_SCF  = 5'd21,
    OP_CCF  = 5'd22,
    OP_RLCA = 5'd23,
    OP_RRCA = 5'd24,
    OP_RLA  = 5'd25,
    OP_RRA  = 5'd26,
    OP_INC  = 5'd27,
    OP_DEC  = 5'd28
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic       z_in;
    logic       n_in;
    logic       h_in;
    logic       c_in;
  } item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    logic       z_out;
    logic       n_out;
    logic       h_out;
    logic       c_out;
  } res_t;

endpackage

>>> hdl/ebalu_core.sv
// Operation logic of the eight-bit ALU: one item in, one result out, no storage.
// Depends on ebalu_pkg.
module ebalu_core (
  input  ebalu_pkg::item_t item,
  output ebalu_pkg::res_t  res
);
  import ebalu_pkg::*;

  logic [7:0] a;
  logic [7:0] d;
  logic       ci;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [7:0] mask;
  logic       corr6;
  logic       corr60;
  logic [7:0] corr;
  logic [7:0] r;
  logic       wb;
  logic       z;
  logic       n;
  logic       h;
  logic       c;
  logic       set_z;

  assign a      = item.acc_in;
  assign d      = item.operand;
  assign ci     = ((item.op == OP_ADC) || (item.op == OP_SBC)) ? item.c_in : 1'b0;
  assign sum9   = {1'b0, a} + {1'b0, d} + {8'd0, ci};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, ci};
  assign diff9  = {1'b0, a} - {1'b0, d} - {8'd0, ci};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, d[3:0]} - {4'd0, ci};
  assign mask   = 8'd1 << item.bit_index;
  assign corr6  = item.h_in || (!item.n_in && (a[3:0] > 4'h9));
  assign corr60 = item.c_in || (!item.n_in && (a > 8'h99));
  assign corr   = {1'b0, corr60, corr60, 2'b00, corr6, corr6, 1'b0};

  always_comb begin
    r     = 8'd0;
    wb    = 1'b1;
    z     = item.z_in;
    n     = item.n_in;
    h     = item.h_in;
    c     = item.c_in;
    set_z = 1'b1;
    case (item.op)
      OP_ADD, OP_ADC: begin
        r = sum9[7:0]; c = sum9[8]; h = hsum5[4]; n = 1'b0;
      end
      OP_SUB, OP_SBC: begin
        r = diff9[7:0]; c = diff9[8]; h = hdiff5[4]; n = 1'b1;
      end
      OP_CP: begin
        r = a; wb = 1'b0; set_z = 1'b0;
        z = (diff9[7:0] == 8'd0); c = diff9[8]; h = hdiff5[4]; n = 1'b1;
      end
      OP_AND:  begin r = a & d; n = 1'b0; h = 1'b1; c = 1'b0; end
      OP_XOR:  begin r = a ^ d; n = 1'b0; h = 1'b0; c = 1'b0; end
      OP_OR:   begin r = a | d; n = 1'b0; h = 1'b0; c = 1'b0; end
      OP_RLC:  begin r = {d[6:0], d[7]}; c = d[7]; n = 1'b0; h = 1'b0; end
      OP_RRC:  begin r = {d[0], d[7:1]}; c = d[0]; n = 1'b0; h = 1'b0; end
      OP_RL:   begin r = {d[6:0], item.c_in}; c = d[7]; n = 1'b0; h = 1'b0; end
      OP_RR:   begin r = {item.c_in, d[7:1]}; c = d[0]; n = 1'b0; h = 1'b0; end
      OP_SLA:  begin r = {d[6:0], 1'b0}; c = d[7]; n = 1'b0; h = 1'b0; end
      OP_SRA:  begin r = {d[7], d[7:1]}; c = d[0]; n = 1'b0; h = 1'b0; end
      OP_SWAP: begin r = {d[3:0], d[7:4]}; c = 1'b0; n = 1'b0; h = 1'b0; end
      OP_SRL:  begin r = {1'b0, d[7:1]}; c = d[0]; n = 1'b0; h = 1'b0; end
      OP_BIT: begin
        r = d; wb = 1'b0; set_z = 1'b0;
        z = ((d & mask) == 8'd0); n = 1'b0; h = 1'b1;
      end
      OP_RES: begin r = d & ~mask; set_z = 1'b0; end
      OP_SET: begin r = d | mask; set_z = 1'b0; end
      OP_DAA: begin
        r = item.n_in ? (a - corr) : (a + corr);
        c = item.c_in | corr60;
        h = 1'b0;
      end
      OP_CPL: begin r = ~a; n = 1'b1; h = 1'b1; set_z = 1'b0; end
      OP_SCF: begin r = a; c = 1'b1; n = 1'b0; h = 1'b0; set_z = 1'b0; end
      OP_CCF: begin r = a; c = ~item.c_in; n = 1'b0; h = 1'b0; set_z = 1'b0; end
      OP_RLCA: begin
        r = {a[6:0], a[7]}; c = a[7]; z = 1'b0; n = 1'b0; h = 1'b0; set_z = 1'b0;
      end
      OP_RRCA: begin
        r = {a[0], a[7:1]}; c = a[0]; z = 1'b0; n = 1'b0; h = 1'b0; set_z = 1'b0;
      end
      OP_RLA: begin
        r = {a[6:0], item.c_in}; c = a[7]; z = 1'b0; n = 1'b0; h = 1'b0; set_z = 1'b0;
      end
      OP_RRA: begin
        r = {item.c_in, a[7:1]}; c = a[0]; z = 1'b0; n = 1'b0; h = 1'b0; set_z = 1'b0;
      end
      OP_INC: begin r = d + 8'd1; h = (d[3:0] == 4'hF); n = 1'b0; end
      OP_DEC: begin r = d - 8'd1; h = (d[3:0] == 4'h0); n = 1'b1; end
      default: begin
        r = 8'd0; wb = 1'b0; set_z = 1'b0;
      end
    endcase
    if (set_z) begin
      z = (r == 8'd0);
    end
  end

  assign res = '{result: r, write_back: wb, z_out: z, n_out: n, h_out: h, c_out: c};

endmodule

>>> hdl/eight_bit_alu_with_flags.sv
// Eight-bit ALU with flags, a small 8-bit processor's arithmetic/logic unit behind a stream pair.
// A transfer on the input side yields exactly one result transfer, passing through the input register
// and then the result register around the combinational operation logic; a new item is taken every
// cycle while the output is not stalled, and throughput is then one item per clock.
// Unused operation codes 29 to 31 give a zero result, no write-back and unchanged flags.
// Depends on ebalu_pkg, ebalu_core and eight_bit_alu_with_flags_defines.svh.
`include "eight_bit_alu_with_flags_defines.svh"
module eight_bit_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] acc_in, [15:8] operand, [18:16] bit_index, [19] z_in, [20] n_in, [21] h_in,
  // [22] c_in, [23] zero
  input  logic [23:0] in_tdata,
  // [4:0] op
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] result, [8] z_out, [9] n_out, [10] h_out, [11] c_out, [15:12] zero
  output logic [15:0] out_tdata,
  // [0] write_back
  output logic        out_tuser
);
  import ebalu_pkg::*;

  logic  in_v_r;
  item_t in_r;
  logic  out_v_r;
  res_t  out_r;
  res_t  res_nxt;
  logic  out_adv;

  assign out_adv   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= '{op: op_t'(in_tuser), acc_in: in_tdata[7:0], operand: in_tdata[15:8],
                bit_index: in_tdata[18:16], z_in: in_tdata[19], n_in: in_tdata[20],
                h_in: in_tdata[21], c_in: in_tdata[22]};
    end
  end

  ebalu_core u_core (
    .item (in_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_v_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r.c_out, out_r.h_out, out_r.n_out, out_r.z_out, out_r.result};
  assign out_tuser  = out_r.write_back;

  `EBALU_ASSERT_IMP(a_stall_cause, !in_tready, in_v_r && out_v_r && !out_tready)
  `EBALU_ASSERT_NXT(a_item_moves, out_adv && in_v_r, out_v_r)
  `EBALU_ASSERT_NXT(a_no_wb_cp_bit,
    out_adv && in_v_r && (in_r.op == OP_CP || in_r.op == OP_BIT), !out_tuser)
  `EBALU_ASSERT_NXT(a_acc_rot_clear_z,
    out_adv && in_v_r && (in_r.op == OP_RLCA || in_r.op == OP_RRCA ||
    in_r.op == OP_RLA || in_r.op == OP_RRA), !out_tdata[8])

endmodule
